// File: design/cws_pkg.sv
`default_nettype none

package cws_pkg;

  // input word: the sample and eleven gains
  localparam int NUM_GAINS  = 11;
  localparam int NUM_FIELDS = NUM_GAINS + 1;

  // polynomial values carry this many fraction bits
  localparam int TFRAC = 30;

  // headroom of a polynomial value over its fraction bits, sign bit included
  localparam int T_GUARD = 3;

  // headroom of the accumulator over one gain product
  localparam int ACC_GUARD = 4;

  // integer bits added to the sample width on the result
  localparam int OUT_GUARD = 4;

endpackage

`default_nettype wire

// File: design/chebyshev_waveshaper.sv
// Chebyshev waveshaper: per sample, the sum g1*T1(x) + ... + gN*TN(x), N = MAX_ORDER.
// Input channel s_axis: one word carries the sample x and gains 1..11, all signed
// Q1.(SAMPLE_WIDTH-1); gains above MAX_ORDER are ignored.
// Output channel m_axis: one word per input word, the signed Q5.(SAMPLE_WIDTH-1) sum,
// rounded half up and clamped to SAMPLE_WIDTH+4 bits.
// The polynomials run down a row of cells: each cell forms the next Tk from the two
// before it and adds the weighted term of the one it received, one multiply-add each.
// Path from input handshake to tvalid: one input register, MAX_ORDER-1 cells,
// one final sum stage and the output register.
// Throughput: one word per cycle while the receiver takes words.
// Every stage moves together; s_axis_tready is high whenever the output register is
// empty or is being read, so a stall on m_axis_tready freezes the whole row and drops
// s_axis_tready in the same cycle. No word is lost or repeated.
// Reset clears all valid flags; the block keeps no state between words.
`default_nettype none

module chebyshev_waveshaper #(
  parameter int MAX_ORDER    = 11,
  parameter int SAMPLE_WIDTH = 16,
  localparam int InW  = ((cws_pkg::NUM_FIELDS * SAMPLE_WIDTH + 7) / 8) * 8,
  localparam int OutW = ((SAMPLE_WIDTH + cws_pkg::OUT_GUARD + 7) / 8) * 8
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             s_axis_tvalid,
  output logic            s_axis_tready,
  // sample_in, gain_1, gain_2, ... gain_11, SAMPLE_WIDTH bits each
  input  wire [InW-1:0]   s_axis_tdata,
  output logic            m_axis_tvalid,
  input  wire             m_axis_tready,
  // shaped_out, zero filled above
  output logic [OutW-1:0] m_axis_tdata
);

  import cws_pkg::*;

  localparam int SW = SAMPLE_WIDTH;
  localparam int TW = TFRAC + T_GUARD;
  localparam int AW = SW + TW + ACC_GUARD;
  localparam int OW = SW + OUT_GUARD;
  localparam int GW = MAX_ORDER * SW;
  localparam logic [TW-1:0] TOne = TW'(64'd1 << TFRAC);

  logic en;

  logic                 head_valid_q;
  logic signed [SW-1:0] head_x_q;
  logic        [GW-1:0] head_gains_q, gains_in;

  logic                 vld_w   [MAX_ORDER];
  logic signed [SW-1:0] x_w     [MAX_ORDER];
  logic signed [TW-1:0] prev_w  [MAX_ORDER];
  logic signed [TW-1:0] cur_w   [MAX_ORDER];
  logic signed [AW-1:0] acc_w   [MAX_ORDER];
  logic        [GW-1:0] gains_w [MAX_ORDER];

  logic signed [OW-1:0] shaped;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  for (genvar g = 0; g < MAX_ORDER; g++) begin : g_gain
    assign gains_in[g*SW +: SW] = s_axis_tdata[(g+1)*SW +: SW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_valid_q <= 1'b0;
    end else if (en) begin
      head_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && s_axis_tvalid) begin
      head_x_q     <= s_axis_tdata[SW-1:0];
      head_gains_q <= gains_in;
    end
  end

  // T0 = 1 and T1 = x at the polynomial scale, nothing summed yet
  assign vld_w[0]   = head_valid_q;
  assign x_w[0]     = head_x_q;
  assign prev_w[0]  = $signed(TOne);
  assign cur_w[0]   = $signed({{(TW-SW){head_x_q[SW-1]}}, head_x_q}) <<< (TFRAC - (SW - 1));
  assign acc_w[0]   = '0;
  assign gains_w[0] = head_gains_q;

  for (genvar k = 0; k < MAX_ORDER - 1; k++) begin : g_cell
    cws_cell #(
      .SW (SW),
      .TW (TW),
      .AW (AW),
      .GW (GW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (vld_w[k]),
      .x_i     (x_w[k]),
      .prev_i  (prev_w[k]),
      .cur_i   (cur_w[k]),
      .acc_i   (acc_w[k]),
      .gains_i (gains_w[k]),
      .valid_o (vld_w[k+1]),
      .x_o     (x_w[k+1]),
      .prev_o  (prev_w[k+1]),
      .cur_o   (cur_w[k+1]),
      .acc_o   (acc_w[k+1]),
      .gains_o (gains_w[k+1])
    );
  end

  cws_tail #(
    .SW (SW),
    .TW (TW),
    .AW (AW),
    .OW (OW)
  ) u_tail (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vld_w[MAX_ORDER-1]),
    .cur_i   (cur_w[MAX_ORDER-1]),
    .acc_i   (acc_w[MAX_ORDER-1]),
    .gain_i  (gains_w[MAX_ORDER-1][SW-1:0]),
    .valid_o (m_axis_tvalid),
    .data_o  (shaped)
  );

  assign m_axis_tdata = OutW'($unsigned(shaped));

  a_head_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> head_valid_q)
    else $error("accepted word missing from the input register");

  a_row_frozen : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(head_valid_q) && $stable(vld_w[MAX_ORDER-1]))
    else $error("cell row moved while the output was stalled");

endmodule

`default_nettype wire

// File: design/cws_cell.sv
`default_nettype none

module cws_cell #(
  parameter int SW = 16,
  parameter int TW = 33,
  parameter int AW = 53,
  parameter int GW = 176
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  en_i,
  input  wire                  valid_i,
  input  wire signed [SW-1:0]  x_i,
  input  wire signed [TW-1:0]  prev_i,
  input  wire signed [TW-1:0]  cur_i,
  input  wire signed [AW-1:0]  acc_i,
  input  wire        [GW-1:0]  gains_i,
  output logic                 valid_o,
  output logic signed [SW-1:0] x_o,
  output logic signed [TW-1:0] prev_o,
  output logic signed [TW-1:0] cur_o,
  output logic signed [AW-1:0] acc_o,
  output logic       [GW-1:0]  gains_o
);

  localparam int PW    = SW + TW;
  localparam int Shift = SW - 2;
  localparam logic [PW-1:0] Half = PW'(64'd1 << (Shift - 1));

  logic signed [PW-1:0] x_ext, cur_ext, g_ext, prod, rnd, gprod;
  logic signed [TW-1:0] cur_d;
  logic signed [AW-1:0] acc_d;

  logic                 valid_q;
  logic signed [SW-1:0] x_q;
  logic signed [TW-1:0] prev_q, cur_q;
  logic signed [AW-1:0] acc_q;
  logic        [GW-1:0] gains_q;

  always_comb begin
    x_ext   = {{(PW-SW){x_i[SW-1]}}, x_i};
    g_ext   = {{(PW-SW){gains_i[SW-1]}}, gains_i[SW-1:0]};
    cur_ext = {{(PW-TW){cur_i[TW-1]}}, cur_i};
    // 2*x*T(k) at the polynomial scale, rounded half up
    prod    = x_ext * cur_ext;
    rnd     = (prod + $signed(Half)) >>> Shift;
    cur_d   = $signed(rnd[TW-1:0]) - prev_i;
    // weight the incoming term while the next one is formed
    gprod   = g_ext * cur_ext;
    acc_d   = acc_i + {{(AW-PW){gprod[PW-1]}}, gprod};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q     <= x_i;
      prev_q  <= cur_i;
      cur_q   <= cur_d;
      acc_q   <= acc_d;
      gains_q <= gains_i >> SW;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign prev_o  = prev_q;
  assign cur_o   = cur_q;
  assign acc_o   = acc_q;
  assign gains_o = gains_q;

endmodule

`default_nettype wire

// File: design/cws_tail.sv
`default_nettype none

module cws_tail #(
  parameter int SW = 16,
  parameter int TW = 33,
  parameter int AW = 53,
  parameter int OW = 20
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  en_i,
  input  wire                  valid_i,
  input  wire signed [TW-1:0]  cur_i,
  input  wire signed [AW-1:0]  acc_i,
  input  wire signed [SW-1:0]  gain_i,
  output logic                 valid_o,
  output logic signed [OW-1:0] data_o
);

  import cws_pkg::*;

  localparam int PW = SW + TW;
  localparam logic [AW-1:0] Half = AW'(64'd1 << (TFRAC - 1));
  localparam logic [OW-1:0] MaxPos = {1'b0, {(OW-1){1'b1}}};
  localparam logic [OW-1:0] MaxNeg = {1'b1, {(OW-1){1'b0}}};

  logic signed [PW-1:0] g_ext, cur_ext, gprod;
  logic signed [AW-1:0] acc_d, scaled;
  logic [AW-OW:0]       hi_bits;
  logic signed [OW-1:0] data_d;

  logic                 valid_q, out_valid_q;
  logic signed [AW-1:0] acc_q;
  logic signed [OW-1:0] data_q;

  always_comb begin
    g_ext   = {{(PW-SW){gain_i[SW-1]}}, gain_i};
    cur_ext = {{(PW-TW){cur_i[TW-1]}}, cur_i};
    gprod   = g_ext * cur_ext;
    acc_d   = acc_i + {{(AW-PW){gprod[PW-1]}}, gprod};
  end

  // round to the sample fraction and clamp
  always_comb begin
    scaled  = (acc_q + $signed(Half)) >>> TFRAC;
    hi_bits = scaled[AW-1:OW-1];
    if ((&hi_bits) || !(|hi_bits)) begin
      data_d = scaled[OW-1:0];
    end else if (scaled[AW-1]) begin
      data_d = $signed(MaxNeg);
    end else begin
      data_d = $signed(MaxPos);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q     <= valid_i;
      out_valid_q <= valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      acc_q  <= acc_d;
      data_q <= data_d;
    end
  end

  assign valid_o = out_valid_q;
  assign data_o  = data_q;

  a_rise_from_sum : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(valid_q))
    else $error("result word appeared without a finished sum");

  a_sign_kept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && valid_q && !acc_q[AW-1] |=> !data_q[OW-1])
    else $error("non-negative sum gave a negative result");

  a_hold_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(data_q) && $stable(out_valid_q))
    else $error("result register moved while stalled");

endmodule

`default_nettype wire
